FILE: src/lsbse_pkg.sv
// Shared types and constants of the LSB steganography byte embedder.
package lsbse_pkg;

	localparam int unsigned ROW_W     = 16;  // row_bytes and row position width
	localparam int unsigned PAD_W     = 2;   // pad_bytes and padding counter width
	localparam int unsigned MLEN_W    = 13;  // message_length width
	localparam int unsigned BIT_IDX_W = 17;  // payload bit index, up to (8191 + 4) * 8
	localparam int unsigned BYTE_IDX_W = BIT_IDX_W - 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0] HIDE_KEY = 8'd53;
	localparam logic [BYTE_IDX_W-1:0] LEN_BYTES = BYTE_IDX_W'(4);

	// request kinds on the input stream
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_CARRIER = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BYTES      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 2'd2;

	// control carried alongside the store read
	typedef struct packed {
		logic [7:0] carrier;
		logic       embed;
		logic       is_len;
		logic [7:0] len_byte;
		logic [2:0] bit_pos;
		logic       done;
	} ctl_t;

endpackage

FILE: src/lsb_stego_byte_embedder_unit.sv
// Top level of the LSB steganography byte embedder.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the request kind. A load request
//   (tuser = 0) writes tdata[7:0] into the message store at the next load
//   position and yields no output. A carrier request (tuser = 1) presents a
//   cover image byte in tdata[15:8] and yields exactly one output request.
//   Output stream (m_axis_*): tdata is the carrier byte, its lowest bit
//   replaced when tuser[0] (bit embedded) is set; tuser[1] reports that the
//   whole payload (four length bytes plus the message) has been embedded.
//   Configuration (cfg_*): row_bytes, pad_bytes, message_length; write only
//   while the block is idle. cfg_ready is always high.
//   Path: a carrier byte accepted on the input passes the read stage (s1)
//   and then the output register (s2) before it is offered on the output.
//   Throughput: one request per cycle while the output is not stalled; the
//   message store is written once per load byte and read once per carrier byte, registered.
//   Reset clears counters and pipeline valids and sets the configuration
//   registers to defaults; the message store keeps no reset and must be loaded before use.
//   When the receiver stalls, the output register holds its request and the
//   read stage, if empty, takes one more carrier byte before s_axis_tready drops.
module lsb_stego_byte_embedder_unit #(
	parameter int unsigned MSG_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsbse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsbse_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // [7:0] message_byte, [15:8] carrier_byte
	input  logic                              s_axis_tuser,  // [0] func
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]                        m_axis_tuser   // [0] bit_embedded, [1] payload_done
);
	import lsbse_pkg::*;

	localparam int unsigned AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MSG_DEPTH - 1);
	localparam logic [BIT_IDX_W-1:0] DEPTH_EXT = BIT_IDX_W'(MSG_DEPTH);

	// configuration registers
	logic [ROW_W-1:0]  row_bytes_q;
	logic [PAD_W-1:0]  pad_bytes_q;
	logic [MLEN_W-1:0] message_length_q;

	// stream state
	logic [AW-1:0]        load_ptr_q;
	logic [BIT_IDX_W-1:0] bit_idx_q;
	logic [ROW_W-1:0]     row_pos_q;
	logic [PAD_W-1:0]     pad_left_q;

	// message store
	logic [7:0] mem [MSG_DEPTH];

	// pipeline
	logic       valid_s1;
	ctl_t       ctl_s1;
	logic [7:0] rdata_s1;
	logic       valid_s2;
	logic [7:0] out_byte_s2;
	logic       embedded_s2;
	logic       done_s2;

	logic adv_s1, adv_s2, in_acc, load_acc, car_acc;

	// per-carrier control
	logic [MLEN_W-1:0]     eff_len;
	logic [BIT_IDX_W-1:0]  total_bits;
	logic [ROW_W-1:0]      row_limit;
	logic [ROW_W:0]        row_pos_inc;
	logic                  in_pad, embed, row_end;
	logic [BIT_IDX_W-1:0]  bit_idx_nxt;
	logic [BYTE_IDX_W-1:0] byte_idx, msg_idx;
	logic [7:0]            len_part, len_byte;
	logic [AW-1:0]         rd_addr;
	ctl_t                  ctl_nxt;
	logic [7:0]            payload_byte;
	logic                  payload_bit;

	// handshakes: the output register frees as it drains, the read stage behind it
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign load_acc      = in_acc && (s_axis_tuser == FUNC_LOAD);
	assign car_acc       = in_acc && (s_axis_tuser == FUNC_CARRIER);
	assign cfg_ready     = 1'b1;

	// effective length, capped at the store depth, and payload size in bits
	always_comb begin
		if ({{(BIT_IDX_W-MLEN_W){1'b0}}, message_length_q} > DEPTH_EXT) begin
			eff_len = MLEN_W'(MSG_DEPTH);
		end else begin
			eff_len = message_length_q;
		end
		total_bits = {({1'b0, eff_len} + (MLEN_W+1)'(LEN_BYTES)), 3'b000};
	end

	// row tracking and bit index advance
	always_comb begin
		row_limit   = (row_bytes_q == '0) ? ROW_W'(1) : row_bytes_q;
		row_pos_inc = {1'b0, row_pos_q} + (ROW_W+1)'(1);
		in_pad      = (pad_left_q != '0);
		embed       = !in_pad && (bit_idx_q < total_bits);
		row_end     = !in_pad && (row_pos_inc >= {1'b0, row_limit});
		bit_idx_nxt = bit_idx_q + BIT_IDX_W'(embed);
	end

	// payload byte selection: four length bytes, then the stored message
	always_comb begin
		byte_idx = bit_idx_q[BIT_IDX_W-1:3];
		msg_idx  = byte_idx - LEN_BYTES;
		rd_addr  = AW'(msg_idx);
		case (byte_idx[1:0])
			2'd2:    len_part = {3'b000, eff_len[MLEN_W-1:8]};
			2'd3:    len_part = eff_len[7:0];
			default: len_part = 8'd0;
		endcase
		len_byte = (HIDE_KEY + len_part) ^ HIDE_KEY;

		ctl_nxt.carrier  = s_axis_tdata[15:8];
		ctl_nxt.embed    = embed;
		ctl_nxt.is_len   = (byte_idx < LEN_BYTES);
		ctl_nxt.len_byte = len_byte;
		ctl_nxt.bit_pos  = bit_idx_q[2:0];
		ctl_nxt.done     = (bit_idx_nxt >= total_bits);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q      <= ROW_W'(1);
			pad_bytes_q      <= '0;
			message_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_BYTES:      row_bytes_q      <= cfg_data[ROW_W-1:0];
				REG_PAD_BYTES:      pad_bytes_q      <= cfg_data[PAD_W-1:0];
				REG_MESSAGE_LENGTH: message_length_q <= cfg_data[MLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// counters: load pointer wraps at the store end; row and padding per carrier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			bit_idx_q  <= '0;
			row_pos_q  <= '0;
			pad_left_q <= '0;
		end else begin
			if (load_acc) begin
				load_ptr_q <= (load_ptr_q == LAST_ADDR) ? '0 : load_ptr_q + AW'(1);
			end
			if (car_acc) begin
				bit_idx_q <= bit_idx_nxt;
				if (in_pad) begin
					pad_left_q <= pad_left_q - PAD_W'(1);
				end else if (row_end) begin
					row_pos_q  <= '0;
					pad_left_q <= pad_bytes_q;
				end else begin
					row_pos_q <= row_pos_inc[ROW_W-1:0];
				end
			end
		end
	end

	// message store: write on load, registered read on carrier
	always_ff @(posedge clk) begin
		if (load_acc) begin
			mem[load_ptr_q] <= s_axis_tdata[7:0];
		end
		if (car_acc) begin
			rdata_s1 <= mem[rd_addr];
			ctl_s1   <= ctl_nxt;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= car_acc;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// bit replacement into the output register
	always_comb begin
		payload_byte = ctl_s1.is_len ? ctl_s1.len_byte : (rdata_s1 ^ HIDE_KEY);
		payload_bit  = payload_byte[3'd7 - ctl_s1.bit_pos];
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_byte_s2 <= ctl_s1.embed ? {ctl_s1.carrier[7:1], payload_bit} : ctl_s1.carrier;
			embedded_s2 <= ctl_s1.embed;
			done_s2     <= ctl_s1.done;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = out_byte_s2;
	assign m_axis_tuser  = {done_s2, embedded_s2};

endmodule
